[rtl/assert_macros.svh]
// Assertion helpers for the RTL. SYNTH builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(name, clk, rst_n, ante, cons)
`define ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

[rtl/wmso_pkg.sv]
package wmso_pkg;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_START_DIST = 3'd1,
        CMD_START_TIME = 3'd2,
        CMD_STOP       = 3'd3,
        CMD_SET_SPEED  = 3'd4,
        CMD_ODO_RESET  = 3'd5
    } cmd_e;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_DIST  = 2'd1,
        MODE_TIME  = 2'd2,
        MODE_BRAKE = 2'd3
    } mode_e;

    typedef enum logic {
        CFG_BRAKE_LEAD = 1'b0,
        CFG_STOP_TICKS = 1'b1
    } cfg_index_e;

    localparam int unsigned IN_DATA_W  = 128;
    localparam int unsigned OUT_DATA_W = 264;
    localparam int unsigned TICKS_W    = 30;

    localparam logic [15:0] BRAKE_LEAD_RST = 16'd0;
    localparam logic [7:0]  STOP_TICKS_RST = 8'd10;
    // Ticks are ceil(ms / 10): (ms + 9) / 2, then divided by 5 with a reciprocal.
    localparam logic [32:0] TICK_ROUND     = 33'd9;
    localparam logic [31:0] DIV5_MAGIC     = 32'hCCCC_CCCD;

    typedef struct packed {
        cmd_e               cmd;
        logic signed [15:0] enc_a;
        logic signed [15:0] enc_b;
        logic signed [31:0] distance_pulses;
        logic signed [15:0] speed_a;
        logic signed [15:0] speed_b;
        logic [31:0]        move_msec;
    } item_t;

    typedef struct packed {
        item_t              item;
        logic [TICKS_W-1:0] ticks;
    } stage_t;

    typedef struct packed {
        logic [15:0] brake_lead;
        logic [7:0]  stop_ticks;
    } cfg_t;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (32'd0 - v) : v;
    endfunction

endpackage

[rtl/wmso_tick_div.sv]
module wmso_tick_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  wmso_pkg::item_t  in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output wmso_pkg::stage_t out_stage
);
    import wmso_pkg::*;

    logic               valid_reg;
    item_t              item_reg;
    logic [TICKS_W-1:0] ticks_reg;
    logic [32:0]        rounded;
    logic [63:0]        product;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        rounded = {1'b0, in_item.move_msec} + TICK_ROUND;
        product = rounded[32:1] * DIV5_MAGIC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg  <= in_item;
            ticks_reg <= product[63:34];
        end
    end

    assign out_valid       = valid_reg;
    assign out_stage.item  = item_reg;
    assign out_stage.ticks = ticks_reg;

endmodule

[rtl/wmso_core.sv]
`include "assert_macros.svh"

module wmso_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wmso_pkg::cfg_t                       cfg,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  wmso_pkg::stage_t                     stg,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [wmso_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import wmso_pkg::*;

    logic        out_valid_reg;
    logic        ld;
    mode_e       mode_reg, mode_next;
    logic        done_reg, done_next;
    logic [7:0]  still_reg, still_next;
    logic [31:0] goal_ticks_reg, goal_ticks_next;
    logic [31:0] goal_pulses_reg, goal_pulses_next;
    logic [31:0] run_ticks_reg, run_ticks_next;
    logic [31:0] sum_a_reg, sum_a_next;
    logic [31:0] sum_b_reg, sum_b_next;
    logic [31:0] odo_a_reg, odo_a_next;
    logic [31:0] odo_b_reg, odo_b_next;
    logic [15:0] spd_a_reg, spd_a_next;
    logic [15:0] spd_b_reg, spd_b_next;

    logic [31:0] ea32, eb32;
    logic [32:0] center_sum;
    logic [33:0] brake_point;
    logic [15:0] dist_mag;
    logic [15:0] dist_spd;
    logic [31:0] dist_goal;
    logic [32:0] move_sum_out;
    logic [32:0] odo_sum_out;

    assign in_ready = !out_valid_reg || m_tready;
    assign ld       = in_valid && in_ready;

    always_comb
    begin
        mode_next        = mode_reg;
        done_next        = done_reg;
        still_next       = still_reg;
        goal_ticks_next  = goal_ticks_reg;
        goal_pulses_next = goal_pulses_reg;
        run_ticks_next   = run_ticks_reg;
        sum_a_next       = sum_a_reg;
        sum_b_next       = sum_b_reg;
        odo_a_next       = odo_a_reg;
        odo_b_next       = odo_b_reg;
        spd_a_next       = spd_a_reg;
        spd_b_next       = spd_b_reg;

        ea32 = {{16{stg.item.enc_a[15]}}, stg.item.enc_a};
        eb32 = {{16{stg.item.enc_b[15]}}, stg.item.enc_b};
        center_sum  = '0;
        brake_point = '0;
        dist_goal   = mag32(stg.item.distance_pulses);
        dist_mag    = stg.item.speed_a[15] ? (16'd0 - stg.item.speed_a) : stg.item.speed_a;
        // Only the most negative speed still has its top bit set; it saturates.
        if (dist_mag[15])
        begin
            dist_mag = 16'h7FFF;
        end
        dist_spd = stg.item.distance_pulses[31] ? (16'd0 - dist_mag) : dist_mag;

        case (stg.item.cmd)
            CMD_TICK:
            begin
                odo_a_next = odo_a_reg + mag32(ea32);
                odo_b_next = odo_b_reg + mag32(eb32);
                if (mode_reg != MODE_IDLE)
                begin
                    sum_a_next = sum_a_reg + ea32;
                    sum_b_next = sum_b_reg + eb32;
                end
                case (mode_reg)
                    MODE_DIST, MODE_TIME:
                    begin
                        run_ticks_next = run_ticks_reg + 32'd1;
                        center_sum  = {1'b0, mag32(sum_a_next)} + {1'b0, mag32(sum_b_next)};
                        brake_point = {2'b00, center_sum[32:1]} + {18'd0, cfg.brake_lead};
                        if ((mode_reg == MODE_DIST && brake_point >= {2'b00, goal_pulses_reg})
                            || (mode_reg == MODE_TIME && run_ticks_next >= goal_ticks_reg))
                        begin
                            spd_a_next = '0;
                            spd_b_next = '0;
                            mode_next  = MODE_BRAKE;
                            still_next = '0;
                        end
                    end
                    MODE_BRAKE:
                    begin
                        if (ea32 == 32'd0 && eb32 == 32'd0)
                        begin
                            if (still_reg < cfg.stop_ticks)
                            begin
                                still_next = still_reg + 8'd1;
                            end
                        end
                        else
                        begin
                            still_next = '0;
                        end
                        if (still_next >= cfg.stop_ticks)
                        begin
                            mode_next = MODE_IDLE;
                            done_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
            CMD_START_DIST:
            begin
                sum_a_next       = '0;
                sum_b_next       = '0;
                run_ticks_next   = '0;
                still_next       = '0;
                goal_pulses_next = dist_goal;
                goal_ticks_next  = '0;
                if (dist_goal == 32'd0 || dist_mag == 16'd0)
                begin
                    spd_a_next = '0;
                    spd_b_next = '0;
                    mode_next  = MODE_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    spd_a_next = dist_spd;
                    spd_b_next = dist_spd;
                    mode_next  = MODE_DIST;
                    done_next  = 1'b0;
                end
            end
            CMD_START_TIME:
            begin
                sum_a_next       = '0;
                sum_b_next       = '0;
                run_ticks_next   = '0;
                still_next       = '0;
                goal_ticks_next  = {{(32-TICKS_W){1'b0}}, stg.ticks};
                goal_pulses_next = '0;
                if (stg.ticks == '0 || (stg.item.speed_a == 16'sd0 && stg.item.speed_b == 16'sd0))
                begin
                    spd_a_next = '0;
                    spd_b_next = '0;
                    mode_next  = MODE_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    spd_a_next = stg.item.speed_a;
                    spd_b_next = stg.item.speed_b;
                    mode_next  = MODE_TIME;
                    done_next  = 1'b0;
                end
            end
            CMD_STOP:
            begin
                spd_a_next = '0;
                spd_b_next = '0;
                if (mode_reg == MODE_DIST || mode_reg == MODE_TIME)
                begin
                    mode_next  = MODE_BRAKE;
                    still_next = '0;
                end
                else if (mode_reg == MODE_IDLE)
                begin
                    done_next = 1'b1;
                end
            end
            CMD_SET_SPEED:
            begin
                spd_a_next = stg.item.speed_a;
                spd_b_next = stg.item.speed_b;
            end
            CMD_ODO_RESET:
            begin
                odo_a_next = '0;
                odo_b_next = '0;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // The state registers double as the result register: they only move when
    // the previous result has been transferred.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            mode_reg        <= MODE_IDLE;
            done_reg        <= 1'b1;
            still_reg       <= '0;
            goal_ticks_reg  <= '0;
            goal_pulses_reg <= '0;
            run_ticks_reg   <= '0;
            sum_a_reg       <= '0;
            sum_b_reg       <= '0;
            odo_a_reg       <= '0;
            odo_b_reg       <= '0;
            spd_a_reg       <= '0;
            spd_b_reg       <= '0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
            if (in_valid)
            begin
                mode_reg        <= mode_next;
                done_reg        <= done_next;
                still_reg       <= still_next;
                goal_ticks_reg  <= goal_ticks_next;
                goal_pulses_reg <= goal_pulses_next;
                run_ticks_reg   <= run_ticks_next;
                sum_a_reg       <= sum_a_next;
                sum_b_reg       <= sum_b_next;
                odo_a_reg       <= odo_a_next;
                odo_b_reg       <= odo_b_next;
                spd_a_reg       <= spd_a_next;
                spd_b_reg       <= spd_b_next;
            end
        end
    end

    always_comb
    begin
        move_sum_out = {1'b0, mag32(sum_a_reg)} + {1'b0, mag32(sum_b_reg)};
        odo_sum_out  = {1'b0, odo_a_reg} + {1'b0, odo_b_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, odo_sum_out[32:1], odo_b_reg, odo_a_reg, move_sum_out[32:1],
                       sum_b_reg, sum_a_reg, run_ticks_reg, done_reg, mode_reg,
                       spd_b_reg, spd_a_reg};

    `ASSERT_IMP(a_active_not_done, clk, rst_n, mode_reg != MODE_IDLE, !done_reg)
    `ASSERT_NXT(a_hold_on_stall, clk, rst_n, out_valid_reg && !m_tready,
        $stable(m_tdata) && m_tvalid)
    `ASSERT_NXT(a_run_count, clk, rst_n,
        ld && stg.item.cmd == CMD_TICK && mode_reg == MODE_TIME,
        run_ticks_reg == $past(run_ticks_reg) + 32'd1)

endmodule

[rtl/wheel_motion_sequencer_odometer.sv]
// Two-wheel motion sequencer with pulse odometers.
// Commands enter on the s_ stream: s_tuser holds the command code, s_tdata the
// encoder deltas, move distance, speeds and duration. Every command returns
// exactly one status item on the m_ stream with the speed targets, motion
// state, done flag, per-move totals and odometers as they stand after it.
// Configuration (brake lead, stop settle ticks) is written through the cfg_
// channel, which is always ready; write it only while no command is in flight.
// One command per cycle is sustained while the receiver keeps m_tready high; the
// path is a three-stage pipeline: input register, the 32x32 reciprocal multiply
// that turns milliseconds into ticks, and the state update that loads the result.
// Each stage holds its item while the next one is full, so when the receiver
// stalls up to three commands are buffered before s_tready drops.
// Reset clears the pipeline, sets the sequencer idle with done high, zeroes all
// counters, targets and odometers, and restores the configuration defaults.
module wheel_motion_sequencer_odometer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // enc_a[15:0], enc_b[31:16], distance_pulses[63:32], speed_a[79:64],
    // speed_b[95:80], move_msec[127:96]
    input  logic [wmso_pkg::IN_DATA_W-1:0]    s_tdata,
    // cmd[2:0]
    input  logic [2:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // spd_tgt_a[15:0], spd_tgt_b[31:16], run_mode[33:32], done_res[34],
    // elapsed_ticks[66:35], move_total_a[98:67], move_total_b[130:99],
    // move_center[162:131], odo_a[194:163], odo_b[226:195], odo_center[258:227]
    output logic [wmso_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [15:0]                       cfg_data
);
    import wmso_pkg::*;

    logic   in_valid_reg;
    item_t  in_item_reg;
    logic   div_ready;
    logic   stg_valid;
    logic   core_ready;
    stage_t stg;
    cfg_t   cfg_reg;

    assign s_tready  = !in_valid_reg || div_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.cmd             <= cmd_e'(s_tuser);
            in_item_reg.enc_a           <= s_tdata[15:0];
            in_item_reg.enc_b           <= s_tdata[31:16];
            in_item_reg.distance_pulses <= s_tdata[63:32];
            in_item_reg.speed_a         <= s_tdata[79:64];
            in_item_reg.speed_b         <= s_tdata[95:80];
            in_item_reg.move_msec       <= s_tdata[127:96];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brake_lead <= BRAKE_LEAD_RST;
            cfg_reg.stop_ticks <= STOP_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_e'(cfg_index))
                CFG_BRAKE_LEAD: cfg_reg.brake_lead <= cfg_data;
                CFG_STOP_TICKS: cfg_reg.stop_ticks <= cfg_data[7:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    wmso_tick_div u_tick_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_ready  (div_ready),
        .in_item   (in_item_reg),
        .out_valid (stg_valid),
        .out_ready (core_ready),
        .out_stage (stg)
    );

    wmso_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (stg_valid),
        .in_ready (core_ready),
        .stg      (stg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
